### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Types, codes and constant tables shared by the envelope generator modules.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Transaction function codes on the input channel.
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_CONTROL = 2'd1;
  localparam logic [1:0] FUNC_ATK_DCY = 2'd2;
  localparam logic [1:0] FUNC_SUS_REL = 2'd3;

  // Phase codes as reported on the result channel.
  localparam logic [1:0] PHC_ATTACK  = 2'd0;
  localparam logic [1:0] PHC_DECAY   = 2'd1;
  localparam logic [1:0] PHC_RELEASE = 2'd2;
  localparam logic [1:0] PHC_FROZEN  = 2'd3;

  localparam logic [14:0] LFSR_RELOAD = 15'h7FFF;

  typedef enum logic [3:0] {
    PH_ATTACK  = 4'b0001,
    PH_DECAY   = 4'b0010,
    PH_RELEASE = 4'b0100,
    PH_FROZEN  = 4'b1000
  } phase_t;

  // Rate counter period for each rate select value.
  localparam logic [14:0] PERIOD_TAB [16] = '{
    15'h7F00, 15'h0006, 15'h003C, 15'h0330, 15'h20C0, 15'h6755, 15'h3800, 15'h500E,
    15'h1212, 15'h0222, 15'h1848, 15'h59B8, 15'h3840, 15'h77E2, 15'h7625, 15'h0A93
  };

  typedef struct packed {
    logic [14:0] lfsr;
    logic [7:0]  level;
    logic [4:0]  exp_count;
    phase_t      phase;
    logic        gate;
    logic [3:0]  attack_rate;
    logic [3:0]  decay_rate;
    logic [7:0]  sustain_level;
    logic [3:0]  release_rate;
    logic [3:0]  rate_select;
  } env_state_t;

  // Rate matches per decay or release step at a given level.
  function automatic logic [4:0] level_divisor(input logic [7:0] lv);
    logic [4:0] d;
    if (lv == 8'd0)       d = 5'd1;
    else if (lv <= 8'd6)  d = 5'd30;
    else if (lv <= 8'd14) d = 5'd16;
    else if (lv <= 8'd26) d = 5'd8;
    else if (lv <= 8'd54) d = 5'd4;
    else if (lv <= 8'd93) d = 5'd2;
    else                  d = 5'd1;
    return d;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    case (ph)
      PH_ATTACK:  c = PHC_ATTACK;
      PH_DECAY:   c = PHC_DECAY;
      PH_RELEASE: c = PHC_RELEASE;
      default:    c = PHC_FROZEN;
    endcase
    return c;
  endfunction

endpackage

### design/adsr_step.sv
// ----------------------------------------------------------------------------
// ADSR envelope step
// Next-state logic for one transaction: a tick of the rate counter and
// envelope, or a write to one of the voice registers.
// ----------------------------------------------------------------------------
module adsr_step (
  input  adsr_pkg::env_state_t cur,
  input  logic [1:0]           func,
  input  logic [7:0]           data,
  output adsr_pkg::env_state_t nxt
);
  import adsr_pkg::*;

  logic       match;
  logic [4:0] exp_inc;
  logic       step;

  assign match   = (cur.lfsr == PERIOD_TAB[cur.rate_select]);
  assign exp_inc = cur.exp_count + 5'd1;

  always_comb begin
    case (cur.phase)
      PH_ATTACK:  step = 1'b1;
      PH_DECAY:   step = (exp_inc == level_divisor(cur.level));
      PH_RELEASE: step = (exp_inc == level_divisor(cur.level));
      default:    step = 1'b0;
    endcase
  end

  always_comb begin
    nxt = cur;
    case (func)
      FUNC_TICK: begin
        if (!match) begin
          nxt.lfsr = {cur.lfsr[13:0], cur.lfsr[14] ^ cur.lfsr[13]};
        end else begin
          nxt.lfsr = LFSR_RELOAD;
          if (cur.phase == PH_DECAY || cur.phase == PH_RELEASE) begin
            nxt.exp_count = exp_inc;
          end
          if (step) begin
            nxt.exp_count = 5'd0;
            case (cur.phase)
              PH_ATTACK: begin
                nxt.level = cur.level + 8'd1;
                if (cur.level == 8'hFE) begin
                  nxt.phase       = PH_DECAY;
                  nxt.rate_select = cur.decay_rate;
                end
              end
              PH_DECAY: begin
                if (cur.level != cur.sustain_level) begin
                  nxt.level = cur.level - 8'd1;
                  if (cur.level == 8'd1) nxt.phase = PH_FROZEN;
                end
              end
              PH_RELEASE: begin
                nxt.level = cur.level - 8'd1;
                if (cur.level == 8'd1) nxt.phase = PH_FROZEN;
              end
              default: ;
            endcase
          end
        end
      end
      FUNC_CONTROL: begin
        if (data[0] != cur.gate) begin
          nxt.gate = data[0];
          if (data[0]) begin
            nxt.phase       = PH_ATTACK;
            nxt.rate_select = cur.attack_rate;
          end else begin
            nxt.phase       = PH_RELEASE;
            nxt.rate_select = cur.release_rate;
          end
        end
      end
      FUNC_ATK_DCY: begin
        nxt.attack_rate = data[7:4];
        nxt.decay_rate  = data[3:0];
        if (cur.phase == PH_ATTACK)     nxt.rate_select = data[7:4];
        else if (cur.phase == PH_DECAY) nxt.rate_select = data[3:0];
      end
      default: begin
        nxt.sustain_level = {data[7:4], data[7:4]};
        nxt.release_rate  = data[3:0];
        if (cur.phase == PH_RELEASE) nxt.rate_select = data[3:0];
      end
    endcase
  end

endmodule

### design/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// One-voice attack/decay/sustain/release envelope driven by tick and
// register-write transactions.
// ----------------------------------------------------------------------------
// The generator takes one transaction per clock cycle while the result side
// is not stalled, and returns one result transaction for each. An accepted
// transaction moves from the input register through the next-state stage
// into the result register, which presents it. A transaction is either a tick,
// which advances the 15-bit rate LFSR and possibly steps the envelope, or a
// write of the control byte (gate in bit 0), the attack/decay nibbles or the
// sustain/release nibbles. Each result carries the envelope level and phase
// after that transaction. The throughput is set by the single next-state
// stage between the input register and the result register; that stage reads
// and updates the envelope state in the same cycle, so consecutive
// transactions never wait on each other. The result register lets the block
// accept a new transaction while an earlier result still waits to be taken.
module adsr_envelope_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_level,
  output logic [1:0] out_phase
);
  import adsr_pkg::*;

  // Input register: holds the accepted transaction until it is processed.
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_func_r;
  logic [7:0] s1_data_r;

  // Envelope state, updated as each transaction passes to the result stage.
  env_state_t state_r, state_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_level_r;
  logic [1:0] out_phase_r;

  logic advance;
  logic in_take;

  // A transaction leaves the input register when the result register is
  // empty or its current content is being taken in this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  adsr_step u_step (
    .cur  (state_r),
    .func (s1_func_r),
    .data (s1_data_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.lfsr          <= LFSR_RELOAD;
      state_r.level         <= 8'd0;
      state_r.exp_count     <= 5'd0;
      state_r.phase         <= PH_FROZEN;
      state_r.gate          <= 1'b0;
      state_r.attack_rate   <= 4'd0;
      state_r.decay_rate    <= 4'd0;
      state_r.sustain_level <= 8'd0;
      state_r.release_rate  <= 4'd0;
      state_r.rate_select   <= 4'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_level_r <= state_nxt.level;
      out_phase_r <= phase_code(state_nxt.phase);
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

`ifndef NO_ASSERTIONS
  // The input side only holds off while a transaction sits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // Every processed transaction shows up in the result register.
  a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed transaction lost before result register");

  // A frozen envelope does not move its level on a tick.
  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_func_r == FUNC_TICK && state_r.phase == PH_FROZEN)
      |=> $stable(state_r.level))
    else $error("frozen envelope changed level");

  // The rate LFSR never falls into the all-zero lockup state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lfsr != 15'd0)
    else $error("rate LFSR reached zero");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives tick and register-write transactions into the envelope generator,
// predicts level and phase for each one and checks every result in order.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-picked transactions that walks
// through the register extremes, both gate edges, a release that starts from
// zero and an attack that rolls over full scale. After that, random "notes"
// are played: rate and sustain writes, gate on, a run of ticks, gate off and
// another run of ticks, with occasional retriggers and stray writes mixed in.
// Both handshake sides idle at random, except in one quiet window, and the
// result side also holds off once for a long stretch so that the block backs
// up and stalls its input.
module testbench;
  import adsr_pkg::*;

  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYC    = 400;
  localparam int QUIET_FROM  = 1000;
  localparam int QUIET_TO    = 1500;
  localparam int DRAIN_CYC   = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int NOTES       = 4;
  localparam int DIR_ROWS    = 26;

  localparam logic [14:0] LFSR_FULL = 15'h7FFF;

  // Level and phase as carried by one result transaction.
  typedef struct packed {
    logic [7:0] level;
    logic [1:0] phase;
  } env_out_t;

  // One row of the directed stimulus. When typed is set, level and phase are
  // the expected result written out by hand; otherwise the predictor decides.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       typed;
    logic [7:0] level;
    logic [1:0] phase;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [7:0] in_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_level;
  logic [1:0] out_phase;

  int  cyc = 0;
  int  fail_count = 0;
  bit  hold_req = 1'b0;
  logic quiet;

  env_out_t  env_awaited[$];
  stim_row_t dir_rows [DIR_ROWS];

  // Predicted envelope state, kept in step with every accepted transaction.
  logic [14:0] p_lfsr;
  logic [7:0]  p_level;
  logic [4:0]  p_drop_cnt;
  logic [1:0]  p_phase;
  logic        p_gate;
  logic [3:0]  p_atk;
  logic [3:0]  p_dcy;
  logic [7:0]  p_sus;
  logic [3:0]  p_rel;
  logic [3:0]  p_sel;

  adsr_envelope_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level),
    .out_phase (out_phase)
  );

  always #10 clk = ~clk;

  // Both sides stop idling inside this window of cycles.
  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // Free-running cycle count; it also ends a run that has hung.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // LFSR value at which each rate select produces a match.
  function automatic logic [14:0] rate_period(input logic [3:0] sel);
    logic [14:0] p;
    case (sel)
      4'd0:    p = 15'h7F00;
      4'd1:    p = 15'h0006;
      4'd2:    p = 15'h003C;
      4'd3:    p = 15'h0330;
      4'd4:    p = 15'h20C0;
      4'd5:    p = 15'h6755;
      4'd6:    p = 15'h3800;
      4'd7:    p = 15'h500E;
      4'd8:    p = 15'h1212;
      4'd9:    p = 15'h0222;
      4'd10:   p = 15'h1848;
      4'd11:   p = 15'h59B8;
      4'd12:   p = 15'h3840;
      4'd13:   p = 15'h77E2;
      4'd14:   p = 15'h7625;
      default: p = 15'h0A93;
    endcase
    return p;
  endfunction

  // Decay and release slow down at low levels: this many rate matches are
  // needed before the level drops by one.
  function automatic logic [4:0] matches_per_drop(input logic [7:0] lv);
    logic [4:0] n;
    if (lv == 8'd0)       n = 5'd1;
    else if (lv <= 8'd6)  n = 5'd30;
    else if (lv <= 8'd14) n = 5'd16;
    else if (lv <= 8'd26) n = 5'd8;
    else if (lv <= 8'd54) n = 5'd4;
    else if (lv <= 8'd93) n = 5'd2;
    else                  n = 5'd1;
    return n;
  endfunction

  // Applies one transaction to the predicted state and returns the level and
  // phase that the block must report for it.
  function automatic env_out_t env_predict(input logic [1:0] f, input logic [7:0] d);
    env_out_t res;
    logic     stepping;
    stepping = 1'b0;
    case (f)
      FUNC_TICK: begin
        if (p_lfsr != rate_period(p_sel)) begin
          p_lfsr = {p_lfsr[13:0], p_lfsr[14] ^ p_lfsr[13]};
        end else begin
          p_lfsr = LFSR_FULL;
          // Attack steps on every match, decay and release only once enough
          // matches have piled up for the current level.
          if (p_phase == PHC_ATTACK) begin
            stepping = 1'b1;
          end else if (p_phase != PHC_FROZEN) begin
            p_drop_cnt = p_drop_cnt + 5'd1;
            stepping = (p_drop_cnt == matches_per_drop(p_level));
          end
          if (stepping) begin
            p_drop_cnt = 5'd0;
            case (p_phase)
              PHC_ATTACK: begin
                // The level is allowed to roll over from full scale to zero;
                // only landing on full scale ends the attack.
                p_level = p_level + 8'd1;
                if (p_level == 8'hFF) begin
                  p_phase = PHC_DECAY;
                  p_sel = p_dcy;
                end
              end
              PHC_DECAY: begin
                if (p_level != p_sus) begin
                  p_level = p_level - 8'd1;
                  if (p_level == 8'd0) p_phase = PHC_FROZEN;
                end
              end
              PHC_RELEASE: begin
                // Releasing from zero rolls under to full scale.
                p_level = p_level - 8'd1;
                if (p_level == 8'd0) p_phase = PHC_FROZEN;
              end
              default: begin
              end
            endcase
          end
        end
      end
      FUNC_CONTROL: begin
        if (d[0] != p_gate) begin
          if (d[0]) begin
            p_phase = PHC_ATTACK;
            p_sel = p_atk;
          end else begin
            p_phase = PHC_RELEASE;
            p_sel = p_rel;
          end
          p_gate = d[0];
        end
      end
      FUNC_ATK_DCY: begin
        p_atk = d[7:4];
        p_dcy = d[3:0];
        if (p_phase == PHC_ATTACK) p_sel = p_atk;
        else if (p_phase == PHC_DECAY) p_sel = p_dcy;
      end
      default: begin
        p_sus = {d[7:4], d[7:4]};
        p_rel = d[3:0];
        if (p_phase == PHC_RELEASE) p_sel = p_rel;
      end
    endcase
    res.level = p_level;
    res.phase = p_phase;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cyc, what, got, want);
  endtask

  // Offers one transaction, idling first at random, and waits until it is
  // taken. The expected result is queued at the edge that accepts it.
  task automatic offer(input logic [1:0] f, input logic [7:0] d);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    env_awaited.push_back(env_predict(f, d));
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (env_awaited.size() != 0);
  endtask

  // Rates for the notes stay small so that the envelopes move within the run.
  function automatic logic [3:0] small_rate();
    logic [3:0] r;
    if ($urandom_range(9) < 6) r = 4'd0;
    else r = 4'($urandom_range(3, 1));
    return r;
  endfunction

  // A run of ticks with the odd rate write or random transaction mixed in.
  task automatic run_ticks(input int n);
    int k;
    int r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(999);
      if (r < 4) begin
        offer(FUNC_ATK_DCY, {small_rate(), small_rate()});
      end else if (r < 8) begin
        offer(FUNC_SUS_REL, {4'($urandom_range(15)), small_rate()});
      end else if (r < 10) begin
        offer(2'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        offer(FUNC_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  // Transactions with every field random: gate flips, odd rates and so on.
  task automatic noise_burst(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      offer(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // One note: set the rates, press the gate, hold, let go and ring out.
  task automatic play_note(input bit force_long);
    logic [3:0] atk;
    logic [3:0] dcy;
    logic [3:0] rel;
    logic [3:0] sus;
    int         n_on;
    int         n_off;
    int         r;
    atk = small_rate();
    // Most notes use one rate throughout, which keeps the rate counter from
    // overshooting a shorter period when the phase changes.
    if ($urandom_range(2) != 0) begin
      dcy = atk;
      rel = atk;
    end else begin
      dcy = small_rate();
      rel = small_rate();
    end
    r = $urandom_range(9);
    if (r < 3) sus = 4'hF;
    else if (r < 6) sus = 4'h0;
    else sus = 4'($urandom_range(15));
    if (force_long || $urandom_range(2) == 0) n_on = $urandom_range(300, 200);
    else n_on = $urandom_range(120);
    if (force_long || $urandom_range(2) == 0) n_off = $urandom_range(300, 200);
    else n_off = $urandom_range(120);

    offer(FUNC_ATK_DCY, {atk, dcy});
    offer(FUNC_SUS_REL, {sus, rel});
    offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b0});
    offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b1});
    run_ticks(n_on);
    // A quick retrigger; from a full-scale sustain this makes the attack
    // roll over past full scale.
    if ($urandom_range(1) == 0) begin
      offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b0});
      offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b1});
      run_ticks($urandom_range(150));
    end
    offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b0});
    run_ticks(n_off);
    // A blip of gate; after a finished release this releases from zero.
    if ($urandom_range(1) == 0) begin
      offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b1});
      offer(FUNC_CONTROL, {7'($urandom_range(127)), 1'b0});
      run_ticks($urandom_range(60));
    end
  endtask

  // Result side: random stalls, none in the quiet window, and one long
  // hold-off on request while the sender keeps going.
  initial begin : result_side
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      @(posedge clk);
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    env_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (env_awaited.size() == 0) begin
        report_mismatch("result with nothing awaited, level", out_level, 0);
      end else begin
        want = env_awaited.pop_front();
        if (out_level !== want.level) report_mismatch("level", out_level, want.level);
        if (out_phase !== want.phase) report_mismatch("phase", out_phase, want.phase);
      end
    end
  end

  initial begin : stimulus
    int i;
    int n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_TICK;
    in_data  = 8'h00;

    p_lfsr     = LFSR_FULL;
    p_level    = 8'h00;
    p_drop_cnt = 5'd0;
    p_phase    = PHC_FROZEN;
    p_gate     = 1'b0;
    p_atk      = 4'd0;
    p_dcy      = 4'd0;
    p_sus      = 8'h00;
    p_rel      = 4'd0;
    p_sel      = 4'd0;

    // Register writes that do not touch the gate leave a frozen envelope at
    // zero. The gate edges then switch phase at once. With rate zero the
    // counter matches on its ninth step from reload, so the release from zero
    // rolls under on the eighth tick below (the first row already ticked
    // once), and the attack that follows from full scale rolls over on the
    // ninth.
    dir_rows = '{
      '{FUNC_TICK,    8'h00, 1'b1, 8'h00, PHC_FROZEN},
      '{FUNC_CONTROL, 8'hFE, 1'b1, 8'h00, PHC_FROZEN},
      '{FUNC_ATK_DCY, 8'hFF, 1'b1, 8'h00, PHC_FROZEN},
      '{FUNC_SUS_REL, 8'hFF, 1'b1, 8'h00, PHC_FROZEN},
      '{FUNC_CONTROL, 8'hFF, 1'b1, 8'h00, PHC_ATTACK},
      '{FUNC_ATK_DCY, 8'h00, 1'b1, 8'h00, PHC_ATTACK},
      '{FUNC_CONTROL, 8'h00, 1'b1, 8'h00, PHC_RELEASE},
      '{FUNC_SUS_REL, 8'h00, 1'b1, 8'h00, PHC_RELEASE},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_CONTROL, 8'h01, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'h00, 1'b0, 8'h00, PHC_FROZEN},
      '{FUNC_TICK,    8'hFF, 1'b0, 8'h00, PHC_FROZEN}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      offer(dir_rows[i].func, dir_rows[i].data);
      // Hand-written rows replace the prediction that offer just queued.
      if (dir_rows[i].typed) begin
        env_awaited[env_awaited.size() - 1] = {dir_rows[i].level, dir_rows[i].phase};
      end
    end

    // Let the pipeline run dry once before the random part.
    hold_until_drained();

    for (n = 0; n < NOTES; n++) begin
      if (n == 1) hold_req = 1'b1;
      play_note(n == 0);
      noise_burst($urandom_range(30, 10));
    end

    hold_until_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
